FILE: design/hsm_pkg.sv
// shared types and constants for the heater safety monitor
// depends on nothing; imported by every module of the block
package hsm_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// register indexes, address bits [4:2]
	localparam logic [2:0] REG_MAX_TEMP     = 3'd0;
	localparam logic [2:0] REG_MIN_TEMP     = 3'd1;
	localparam logic [2:0] REG_MIN_INTERVAL = 3'd2;
	localparam logic [2:0] REG_MAX_SLOPE    = 3'd3;
	localparam logic [2:0] REG_SLOPE_FLOOR  = 3'd4;
	localparam logic [2:0] REG_MAX_RUNTIME  = 3'd5;

	// reset values of the registers
	localparam logic signed [15:0] RST_MAX_TEMP     = 16'sd9000;
	localparam logic signed [15:0] RST_MIN_TEMP     = -16'sd5000;
	localparam logic [31:0]        RST_MIN_INTERVAL = 32'd1000;
	localparam logic [15:0]        RST_MAX_SLOPE    = 16'd60;
	localparam logic signed [15:0] RST_SLOPE_FLOOR  = 16'sd5000;
	localparam logic [31:0]        RST_MAX_RUNTIME  = 32'd86400000;

	// request operations
	localparam logic [2:0] OP_SAMPLE     = 3'd0;
	localparam logic [2:0] OP_START      = 3'd1;
	localparam logic [2:0] OP_STOP       = 3'd2;
	localparam logic [2:0] OP_SOFT_RESET = 3'd3;
	localparam logic [2:0] OP_HARD_RESET = 3'd4;

	// fault codes
	localparam logic [2:0] FAULT_NONE    = 3'd0;
	localparam logic [2:0] FAULT_INVALID = 3'd1;
	localparam logic [2:0] FAULT_OVER    = 3'd2;
	localparam logic [2:0] FAULT_UNDER   = 3'd3;
	localparam logic [2:0] FAULT_DRY     = 3'd4;
	localparam logic [2:0] FAULT_TIMEOUT = 3'd5;

	// readings below -100 C count as sensor failure
	localparam logic signed [15:0] INVALID_FLOOR = -16'sd10000;
	// centi-degrees per ms to centi-degrees per s
	localparam logic signed [26:0] RISE_SCALE = 27'sd1000;
	localparam logic [31:0] MIN_SLOPE_GAP = 32'd2;

	typedef struct packed {
		logic signed [15:0] max_temperature;
		logic signed [15:0] min_temperature;
		logic [31:0]        min_check_interval;
		logic [15:0]        max_slope;
		logic signed [15:0] slope_check_floor;
		logic [31:0]        max_runtime;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [15:0] temperature;
		logic               sensor_invalid;
		logic [31:0]        now_ms;
	} item_t;

	typedef struct packed {
		logic signed [15:0] last_temp;
		logic [31:0]        last_check_time;
		logic               slope_ready;
		logic               running;
		logic [31:0]        start_time;
		logic [2:0]         fault_state;
		logic signed [15:0] shown_temp;
	} state_t;

endpackage

FILE: design/heater_safety_monitor.sv
// top level of the heater safety monitor: request pipeline and state
// depends on hsm_pkg, hsm_cfg and hsm_eval
//
// usage
// - requests come in on in_valid/in_ready with op, temperature,
//   sensor_invalid and now_ms; every request yields exactly one result on
//   out_valid/out_ready with emergency_stop, fault_code,
//   reported_temperature and is_running, the status after that request
// - limits, slope settings and the watchdog limit sit in six 16- and 32-bit
//   registers at byte addresses 0x00 to 0x14 on the APB-style port;
//   write them only while no request is in flight
// - a request is captured in an input register; once the result register is
//   free or drains, the check logic runs on it and the monitor state and
//   the result register are updated together
// - throughput is one request per cycle unless stalled; the next request
//   sees the state the one before left in the state registers, no bubble
// - when the receiver stalls the result register holds; one more request
//   waits in the input register, after which in_ready drops
// - reset clears all monitor state (no fault, not running, no slope
//   reference), empties both registers and loads the register defaults
module heater_safety_monitor
	import hsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	input  logic signed [15:0] temperature,
	input  logic               sensor_invalid,
	input  logic [31:0]        now_ms,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               emergency_stop,
	output logic [2:0]         fault_code,
	output logic signed [15:0] reported_temperature,
	output logic               is_running
);

	cfg_t   cfg;
	item_t  item_s1;
	logic   valid_s1;
	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   advance;
	logic   in_take;
	// result register
	logic               estop_q;
	logic [2:0]         fault_q;
	logic signed [15:0] temp_q;
	logic               running_q;

	hsm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hsm_eval u_eval (
		.cfg  (cfg),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	// the input stage moves on when the result register is free or drains
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;
	assign in_take  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op             <= op;
			item_s1.temperature    <= temperature;
			item_s1.sensor_invalid <= sensor_invalid;
			item_s1.now_ms         <= now_ms;
		end
	end

	// monitor state, updated once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			estop_q   <= state_nxt.fault_state != FAULT_NONE;
			fault_q   <= state_nxt.fault_state;
			temp_q    <= state_nxt.shown_temp;
			running_q <= state_nxt.running;
		end
	end

	assign out_valid            = out_valid_q;
	assign emergency_stop       = estop_q;
	assign fault_code           = fault_q;
	assign reported_temperature = temp_q;
	assign is_running           = running_q;

endmodule

FILE: design/hsm_cfg.sv
// configuration register file behind the APB-style port
// depends on hsm_pkg for register indexes, reset values and cfg_t
module hsm_cfg
	import hsm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_temperature    <= RST_MAX_TEMP;
			cfg_q.min_temperature    <= RST_MIN_TEMP;
			cfg_q.min_check_interval <= RST_MIN_INTERVAL;
			cfg_q.max_slope          <= RST_MAX_SLOPE;
			cfg_q.slope_check_floor  <= RST_SLOPE_FLOOR;
			cfg_q.max_runtime        <= RST_MAX_RUNTIME;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAX_TEMP:     cfg_q.max_temperature    <= pwdata[15:0];
				REG_MIN_TEMP:     cfg_q.min_temperature    <= pwdata[15:0];
				REG_MIN_INTERVAL: cfg_q.min_check_interval <= pwdata;
				REG_MAX_SLOPE:    cfg_q.max_slope          <= pwdata[15:0];
				REG_SLOPE_FLOOR:  cfg_q.slope_check_floor  <= pwdata[15:0];
				REG_MAX_RUNTIME:  cfg_q.max_runtime        <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAX_TEMP:     prdata = {16'd0, cfg_q.max_temperature};
			REG_MIN_TEMP:     prdata = {16'd0, cfg_q.min_temperature};
			REG_MIN_INTERVAL: prdata = cfg_q.min_check_interval;
			REG_MAX_SLOPE:    prdata = {16'd0, cfg_q.max_slope};
			REG_SLOPE_FLOOR:  prdata = {16'd0, cfg_q.slope_check_floor};
			REG_MAX_RUNTIME:  prdata = cfg_q.max_runtime;
			default:          prdata = '0;
		endcase
	end

endmodule

FILE: design/hsm_eval.sv
// next-state logic: runs one request against the current monitor state
// depends on hsm_pkg for cfg_t, item_t, state_t, op and fault codes
module hsm_eval
	import hsm_pkg::*;
(
	input  cfg_t   cfg,
	input  item_t  item,
	input  state_t cur,
	output state_t nxt
);

	logic signed [15:0] t;
	logic               invalid;
	logic               over;
	logic               under;
	logic [31:0]        d;
	logic               slope_go;
	logic signed [16:0] diff;
	logic signed [26:0] rise;
	logic [47:0]        allow;
	logic               steep;
	logic [31:0]        run_time;
	logic               timeout;

	assign t       = item.temperature;
	assign invalid = item.sensor_invalid | (t < INVALID_FLOOR);
	assign over    = t > cfg.max_temperature;
	assign under   = t < cfg.min_temperature;

	// slope test, cross-multiplied so no divide is needed
	assign d        = item.now_ms - cur.last_check_time;
	assign slope_go = cur.slope_ready & (d >= cfg.min_check_interval) & (d >= MIN_SLOPE_GAP);
	assign diff     = 17'(t) - 17'(cur.last_temp);
	assign rise     = 27'(diff) * RISE_SCALE;
	assign allow    = 48'(cfg.max_slope) * 48'(d);
	assign steep    = ~rise[26] & (48'($unsigned(rise)) > allow)
		& (t > cfg.slope_check_floor);

	// watchdog, elapsed time wraps with the ms counter
	assign run_time = item.now_ms - cur.start_time;
	assign timeout  = cur.running & (run_time > cfg.max_runtime);

	always_comb begin
		nxt = cur;
		case (item.op)
			OP_SAMPLE: begin
				nxt.shown_temp = t;
				if (invalid) begin
					nxt.fault_state = FAULT_INVALID;
					nxt.shown_temp  = '0;
				end else if (over) begin
					nxt.fault_state = FAULT_OVER;
				end else if (under) begin
					nxt.fault_state = FAULT_UNDER;
				end else if (slope_go && steep) begin
					nxt.fault_state = FAULT_DRY;
				end else begin
					// first valid sample or a slope check that passed
					if (!cur.slope_ready || slope_go) begin
						nxt.last_temp       = t;
						nxt.last_check_time = item.now_ms;
					end
					nxt.slope_ready = 1'b1;
					nxt.fault_state = timeout ? FAULT_TIMEOUT : FAULT_NONE;
				end
			end
			OP_START: begin
				if (!cur.running) begin
					nxt.start_time  = item.now_ms;
					nxt.running     = 1'b1;
					nxt.slope_ready = 1'b0;
				end
			end
			OP_STOP: begin
				nxt.running = 1'b0;
			end
			OP_SOFT_RESET: begin
				nxt.fault_state = FAULT_NONE;
			end
			OP_HARD_RESET: begin
				nxt.fault_state     = FAULT_NONE;
				nxt.start_time      = item.now_ms;
				nxt.slope_ready     = 1'b0;
				nxt.last_temp       = '0;
				nxt.last_check_time = '0;
				nxt.running         = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

FILE: tb/hsm_tb_pkg.sv
// status tracker for the heater safety monitor testbench: predicts each result
// from the accepted requests and compares it with what the block returns
// depends on hsm_pkg for the request, limit and code definitions
package hsm_tb_pkg;
	import hsm_pkg::*;

	typedef struct packed {
		logic               emergency_stop;
		logic [2:0]         fault_code;
		logic signed [15:0] reported_temperature;
		logic               is_running;
	} status_t;

	class heater_status_tracker;
		cfg_t               limits;
		logic signed [15:0] ref_temp;
		logic [31:0]        ref_time;
		logic               have_ref;
		logic               armed;
		logic [31:0]        armed_at;
		logic               tripped;
		logic [2:0]         fault;
		logic signed [15:0] shown;
		status_t            pending_status[$];
		int                 mismatches;
		int                 n_requests;
		int                 n_results;
		int                 fault_seen[8];

		function new();
			limits.max_temperature    = RST_MAX_TEMP;
			limits.min_temperature    = RST_MIN_TEMP;
			limits.min_check_interval = RST_MIN_INTERVAL;
			limits.max_slope          = RST_MAX_SLOPE;
			limits.slope_check_floor  = RST_SLOPE_FLOOR;
			limits.max_runtime        = RST_MAX_RUNTIME;
			ref_temp   = '0;
			ref_time   = '0;
			have_ref   = 1'b0;
			armed      = 1'b0;
			armed_at   = '0;
			tripped    = 1'b0;
			fault      = FAULT_NONE;
			shown      = '0;
			mismatches = 0;
			n_requests = 0;
			n_results  = 0;
			foreach (fault_seen[i]) fault_seen[i] = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_MAX_TEMP:     limits.max_temperature    = value[15:0];
				REG_MIN_TEMP:     limits.min_temperature    = value[15:0];
				REG_MIN_INTERVAL: limits.min_check_interval = value;
				REG_MAX_SLOPE:    limits.max_slope          = value[15:0];
				REG_SLOPE_FLOOR:  limits.slope_check_floor  = value[15:0];
				REG_MAX_RUNTIME:  limits.max_runtime        = value;
				default: ;
			endcase
		endfunction

		function void trip(logic [2:0] code);
			tripped = 1'b1;
			fault   = code;
		endfunction

		function void take_sample(logic signed [15:0] t, logic bad, logic [31:0] now);
			logic [31:0] gap_ms;
			logic [31:0] elapsed;
			longint      rise;
			longint      allowed;
			shown = t;
			if (bad || t < INVALID_FLOOR) begin
				trip(FAULT_INVALID);
				shown = '0;
				return;
			end
			if (t > limits.max_temperature) begin
				trip(FAULT_OVER);
				return;
			end
			if (t < limits.min_temperature) begin
				trip(FAULT_UNDER);
				return;
			end
			if (!have_ref) begin
				ref_temp = t;
				ref_time = now;
				have_ref = 1'b1;
			end else begin
				gap_ms = now - ref_time;
				if (gap_ms >= limits.min_check_interval && gap_ms >= MIN_SLOPE_GAP) begin
					rise    = (longint'(t) - longint'(ref_temp)) * 1000;
					allowed = longint'({48'd0, limits.max_slope}) * longint'({32'd0, gap_ms});
					if (rise > allowed && t > limits.slope_check_floor) begin
						trip(FAULT_DRY);
						return;
					end
					ref_temp = t;
					ref_time = now;
				end
			end
			elapsed = now - armed_at;
			if (armed && elapsed > limits.max_runtime) begin
				trip(FAULT_TIMEOUT);
				return;
			end
			tripped = 1'b0;
			fault   = FAULT_NONE;
		endfunction

		function void note_request(item_t r);
			status_t s;
			case (r.op)
				OP_SAMPLE: take_sample(r.temperature, r.sensor_invalid, r.now_ms);
				OP_START: begin
					if (!armed) begin
						armed_at = r.now_ms;
						armed    = 1'b1;
						have_ref = 1'b0;
					end
				end
				OP_STOP: armed = 1'b0;
				OP_SOFT_RESET: begin
					tripped = 1'b0;
					fault   = FAULT_NONE;
				end
				OP_HARD_RESET: begin
					tripped  = 1'b0;
					fault    = FAULT_NONE;
					armed_at = r.now_ms;
					have_ref = 1'b0;
					ref_temp = '0;
					ref_time = '0;
					armed    = 1'b1;
				end
				default: ;
			endcase
			s.emergency_stop       = tripped;
			s.fault_code           = fault;
			s.reported_temperature = shown;
			s.is_running           = armed;
			pending_status.push_back(s);
			n_requests++;
		endfunction

		function void check_status(status_t got);
			status_t want;
			n_results++;
			if (pending_status.size() == 0) begin
				$error("result with no request pending");
				mismatches++;
				return;
			end
			want = pending_status.pop_front();
			fault_seen[want.fault_code]++;
			if (got.emergency_stop !== want.emergency_stop) begin
				$error("emergency_stop: expected %0d, got %0d",
					want.emergency_stop, got.emergency_stop);
				mismatches++;
			end
			if (got.fault_code !== want.fault_code) begin
				$error("fault_code: expected %0d, got %0d", want.fault_code, got.fault_code);
				mismatches++;
			end
			if (got.reported_temperature !== want.reported_temperature) begin
				$error("reported_temperature: expected %0d, got %0d",
					want.reported_temperature, got.reported_temperature);
				mismatches++;
			end
			if (got.is_running !== want.is_running) begin
				$error("is_running: expected %0d, got %0d", want.is_running, got.is_running);
				mismatches++;
			end
		endfunction
	endclass

endpackage

FILE: tb/tb_top.sv
// top level testbench of the heater safety monitor: directed and random requests,
// random stalls on both channels, limit changes over the apb-style port
// depends on hsm_pkg, hsm_tb_pkg and the heater_safety_monitor rtl
module tb_top;
	import hsm_pkg::*;
	import hsm_tb_pkg::*;

	localparam int CYCLE_LIMIT = 300000;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         op;
	logic signed [15:0] temperature;
	logic               sensor_invalid;
	logic [31:0]        now_ms;
	logic               out_valid;
	logic               out_ready;
	logic               emergency_stop;
	logic [2:0]         fault_code;
	logic signed [15:0] reported_temperature;
	logic               is_running;

	heater_status_tracker tracker = new();

	// request generator state: a wrapping millisecond clock and a temperature walk
	logic [31:0] clock_ms  = '0;
	int          walk_temp = 0;
	int          temp_lo   = 0;
	int          temp_hi   = 0;
	int          step_max  = 100;
	int          swing     = 50;
	// stretches with no idling on either side, and the long receiver stall
	bit          tx_steady = 1'b0;
	bit          rx_steady = 1'b0;
	int          rx_hold_cycles = 0;
	int          phases_run = 0;
	int          cycles = 0;

	heater_safety_monitor i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.op                  (op),
		.temperature         (temperature),
		.sensor_invalid      (sensor_invalid),
		.now_ms              (now_ms),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.emergency_stop      (emergency_stop),
		.fault_code          (fault_code),
		.reported_temperature(reported_temperature),
		.is_running          (is_running)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run-time guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// both channels sampled at the rising edge; a result is checked before the
	// request taken at the same edge is noted, so it can never match that request
	always @(posedge clk) begin
		status_t got;
		item_t   req;
		if (out_valid && out_ready) begin
			got.emergency_stop       = emergency_stop;
			got.fault_code           = fault_code;
			got.reported_temperature = reported_temperature;
			got.is_running           = is_running;
			tracker.check_status(got);
		end
		if (in_valid && in_ready) begin
			req.op             = op;
			req.temperature    = temperature;
			req.sensor_invalid = sensor_invalid;
			req.now_ms         = now_ms;
			tracker.note_request(req);
		end
	end

	// result side: random wait per result, plus a long stall on request
	initial begin
		int n;
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_cycles > 0) begin
				n = rx_hold_cycles;
				rx_hold_cycles = 0;
				repeat (n) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end
			gap = rx_steady ? 0 : $urandom_range(0, 4);
			repeat (gap) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// one register write: setup phase, then access phase until pready
	task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.write_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// all six limits; the unused upper half of 16-bit registers gets junk
	task automatic load_limits(logic signed [15:0] hi_lim, logic signed [15:0] lo_lim,
		logic [31:0] gap_min, logic [15:0] slope, logic signed [15:0] dry_floor,
		logic [31:0] runtime);
		cfg_write(REG_MAX_TEMP, {16'($urandom), hi_lim});
		cfg_write(REG_MIN_TEMP, {16'($urandom), lo_lim});
		cfg_write(REG_MIN_INTERVAL, gap_min);
		cfg_write(REG_MAX_SLOPE, {16'($urandom), slope});
		cfg_write(REG_SLOPE_FLOOR, {16'($urandom), dry_floor});
		cfg_write(REG_MAX_RUNTIME, runtime);
		phases_run++;
	endtask

	// request side: random wait, then hold the request until it is taken
	task automatic send(item_t r);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		op             <= r.op;
		temperature    <= r.temperature;
		sensor_invalid <= r.sensor_invalid;
		now_ms         <= r.now_ms;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop offering and wait until every result is back, block idle after that
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic item_t mk(logic [2:0] o, logic signed [15:0] t, logic bad,
		logic [31:0] now);
		item_t r;
		r.op             = o;
		r.temperature    = t;
		r.sensor_invalid = bad;
		r.now_ms         = now;
		return r;
	endfunction

	// temperature window and pace of the clock for one phase
	task automatic aim(int lo, int hi, int step, int sw);
		temp_lo   = lo;
		temp_hi   = hi;
		step_max  = step;
		swing     = sw;
		walk_temp = lo + int'($urandom_range(0, hi - lo));
		clock_ms  = $urandom;
	endtask

	// mostly sessions of samples on an advancing clock with a drifting
	// temperature; some control requests and some fully random noise
	function automatic item_t random_request();
		item_t r;
		int    pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			r.op             = 3'($urandom_range(0, 4));
			r.temperature    = 16'($urandom);
			r.sensor_invalid = 1'($urandom_range(0, 1));
			r.now_ms         = $urandom;
			return r;
		end
		// clock advance: usually a step, sometimes tiny, now and then a jump anywhere
		if ($urandom_range(0, 49) == 0)
			clock_ms = $urandom;
		else if ($urandom_range(0, 9) == 0)
			clock_ms += $urandom_range(0, 3);
		else
			clock_ms += $urandom_range(0, step_max);
		r.now_ms = clock_ms;
		r.op = OP_SAMPLE;
		if (pick < 12)
			r.op = OP_START;
		else if (pick < 15)
			r.op = OP_STOP;
		else if (pick < 18)
			r.op = OP_SOFT_RESET;
		else if (pick < 20)
			r.op = OP_HARD_RESET;
		if (r.op != OP_SAMPLE) begin
			r.temperature    = 16'($urandom);
			r.sensor_invalid = 1'($urandom_range(0, 1));
			return r;
		end
		walk_temp += int'($urandom_range(0, 2 * swing)) - swing;
		if (walk_temp > 32767)
			walk_temp = 32767;
		if (walk_temp < -32768)
			walk_temp = -32768;
		r.sensor_invalid = 1'b0;
		r.temperature    = 16'(walk_temp);
		case ($urandom_range(0, 39))
			0: r.temperature = 16'($urandom);
			1: r.sensor_invalid = 1'b1;
			2: walk_temp = temp_lo + int'($urandom_range(0, temp_hi - temp_lo));
			default: ;
		endcase
		return r;
	endfunction

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			// re-draw the idling style now and then, sometimes no gaps at all
			if (i % 40 == 0) begin
				tx_steady = ($urandom_range(0, 4) == 0);
				rx_steady = ($urandom_range(0, 4) == 0);
			end
			send(random_request());
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		item_t opening[$];
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_valid       = 1'b0;
		op             = OP_SAMPLE;
		temperature    = '0;
		sensor_invalid = 1'b0;
		now_ms         = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part on the reset limits
		// first valid sample only stores the slope reference
		opening.push_back(mk(OP_SAMPLE, 16'sd2000, 1'b0, 32'd100));
		// invalid by flag, by the lowest code, and just below -100 C
		opening.push_back(mk(OP_SAMPLE, 16'sd32767, 1'b1, 32'd150));
		opening.push_back(mk(OP_SAMPLE, -16'sd32768, 1'b0, 32'd200));
		opening.push_back(mk(OP_SAMPLE, -16'sd10001, 1'b0, 32'd250));
		// exactly -100 C is valid but under the limit
		opening.push_back(mk(OP_SAMPLE, -16'sd10000, 1'b0, 32'd300));
		opening.push_back(mk(OP_SAMPLE, 16'sd32767, 1'b0, 32'd350));
		// both limits exactly: no fault, clears
		opening.push_back(mk(OP_SAMPLE, 16'sd9000, 1'b0, 32'd400));
		opening.push_back(mk(OP_SAMPLE, -16'sd5000, 1'b0, 32'd450));
		opening.push_back(mk(OP_SOFT_RESET, 16'sd0, 1'b0, 32'd500));
		// start, then start again while running changes nothing
		opening.push_back(mk(OP_START, 16'sd0, 1'b0, 32'd1000));
		opening.push_back(mk(OP_START, 16'sd0, 1'b0, 32'd5000));
		// slope reference, steep rise above the floor, then a gentle one
		opening.push_back(mk(OP_SAMPLE, 16'sd2000, 1'b0, 32'd1100));
		opening.push_back(mk(OP_SAMPLE, 16'sd6000, 1'b0, 32'd2200));
		opening.push_back(mk(OP_SAMPLE, 16'sd2050, 1'b0, 32'd2300));
		// watchdog one past the limit, then exactly at it
		opening.push_back(mk(OP_SAMPLE, 16'sd2100, 1'b0, 32'd86401001));
		opening.push_back(mk(OP_SAMPLE, 16'sd2100, 1'b0, 32'd86401000));
		// stopped: no watchdog even at the top of the clock
		opening.push_back(mk(OP_STOP, 16'sd0, 1'b0, 32'd86402000));
		opening.push_back(mk(OP_SAMPLE, 16'sd2100, 1'b0, 32'hFFFF_FFFF));
		// hard reset near the wrap, run time counted across it
		opening.push_back(mk(OP_HARD_RESET, 16'sd32767, 1'b1, 32'hFFFF_FFF0));
		opening.push_back(mk(OP_SAMPLE, 16'sd2500, 1'b0, 32'd5));
		opening.push_back(mk(OP_SAMPLE, 16'sd7000, 1'b1, 32'd0));
		opening.push_back(mk(OP_SOFT_RESET, 16'sd0, 1'b0, 32'd10));
		// a start at time zero arms the watchdog like any other time
		opening.push_back(mk(OP_STOP, 16'sd0, 1'b0, 32'd20));
		opening.push_back(mk(OP_START, 16'sd0, 1'b0, 32'd0));
		opening.push_back(mk(OP_SAMPLE, 16'sd3000, 1'b0, 32'd86400001));
		opening.push_back(mk(OP_SAMPLE, 16'sd3000, 1'b0, 32'd86400000));
		foreach (opening[i])
			send(opening[i]);
		settle();

		// reset limits, random traffic with a long receiver stall in the middle
		aim(3000, 8500, 1500, 150);
		run_random(90);
		rx_hold_cycles = 80;
		tx_steady = 1'b1;
		for (int i = 0; i < 12; i++)
			send(random_request());
		tx_steady = 1'b0;
		// sender waits for every result before going on
		settle();
		run_random(80);
		settle();

		// tight slope and short watchdog, slope check on every sample past the minimum slope gap
		load_limits(16'sd9000, -16'sd2000, 32'd0, 16'd20, 16'sd1000, 32'd8000);
		aim(0, 9000, 400, 60);
		run_random(200);
		settle();

		// widest limits
		load_limits(16'sd32767, -16'sd32768, 32'hFFFF_FFFF, 16'hFFFF, -16'sd32768,
			32'hFFFF_FFFF);
		aim(-20000, 30000, 5000, 2000);
		run_random(140);
		settle();

		// narrowest limits
		load_limits(-16'sd32768, 16'sd32767, 32'd0, 16'd0, 16'sd32767, 32'd0);
		aim(-32768, 32767, 300, 4000);
		run_random(60);
		settle();

		// plausible random limits
		load_limits(16'($urandom_range(2000, 12000)), -16'($urandom_range(0, 8000)),
			$urandom_range(0, 3000), 16'($urandom_range(0, 500)),
			16'(int'($urandom_range(0, 11000)) - 2000), $urandom_range(2000, 30000));
		aim(-3000, 11000, 600, 120);
		run_random(180);
		settle();

		// fully random limits
		load_limits(16'($urandom), 16'($urandom), $urandom, 16'($urandom), 16'($urandom),
			$urandom);
		aim(-32768, 32767, 3000, 3000);
		run_random(80);
		settle();

		$display("%0d requests, %0d results over %0d limit settings plus reset limits",
			tracker.n_requests, tracker.n_results, phases_run);
		$display("faults expected: invalid %0d, over %0d, under %0d, dry %0d, timeout %0d",
			tracker.fault_seen[FAULT_INVALID], tracker.fault_seen[FAULT_OVER],
			tracker.fault_seen[FAULT_UNDER], tracker.fault_seen[FAULT_DRY],
			tracker.fault_seen[FAULT_TIMEOUT]);
		if (tracker.mismatches == 0 && tracker.pending_status.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

FILE: files.f
design/hsm_pkg.sv
design/hsm_cfg.sv
design/hsm_eval.sv
design/heater_safety_monitor.sv
tb/hsm_tb_pkg.sv
tb/tb_top.sv
